// ===== rtl/core/cpt_pkg.sv =====
// Package: shared types, operation codes and control word layout for the timer block.
`default_nettype none
package cpt_pkg;

    // Operation codes carried by an input beat.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Control word bit positions.
    localparam int CTRL_CASC_BIT = 2;
    localparam int CTRL_IRQ_BIT  = 6;
    localparam int CTRL_EN_BIT   = 7;

    // Number of timers that have an interrupt pulse bit.
    localparam int IRQ_WIDTH = 4;

    typedef struct packed {
        logic        tick;
        logic        wr_count;
        logic        wr_ctrl;
        logic [15:0] data;
    } timer_cmd_t;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] ctrl;
        logic        ovf;
    } timer_stat_t;

    // Prescale period: twice the selected divider of 1, 64, 256 or 1024.
    function automatic logic [11:0] prescale_period(input logic [1:0] sel);
        logic [11:0] period;
        case (sel)
            2'd0:    period = 12'd2;
            2'd1:    period = 12'd128;
            2'd2:    period = 12'd512;
            2'd3:    period = 12'd2048;
            default: period = 12'd2;
        endcase
        return period;
    endfunction

    function automatic logic [15:0] pack_ctrl(input logic [1:0] sel, input logic casc,
                                              input logic irq_en, input logic en);
        logic [15:0] word;
        word                = 16'h0000;
        word[1:0]           = sel;
        word[CTRL_CASC_BIT] = casc;
        word[CTRL_IRQ_BIT]  = irq_en;
        word[CTRL_EN_BIT]   = en;
        return word;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cpt_in_if.sv =====
// Interface: input channel carrying tick, read and write requests.
`default_nettype none
interface cpt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  offset;
    logic [15:0] write_data;

    modport source (output valid, op, offset, write_data, input ready);
    modport sink   (input valid, op, offset, write_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cpt_out_if.sv =====
// Interface: result channel carrying read data and interrupt pulses.
`default_nettype none
interface cpt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [3:0]  irq_pulses;

    modport source (output valid, read_data, irq_pulses, input ready);
    modport sink   (input valid, read_data, irq_pulses, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cpt_timer.sv =====
// Module: one 16-bit up-counting timer with prescaler, reload and cascade input.
`default_nettype none
module cpt_timer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cpt_pkg::timer_cmd_t cmd,
    input  wire logic                carry_in,
    output cpt_pkg::timer_stat_t     stat
);

    logic [15:0] count_reg, count_next;
    logic [15:0] reload_reg, reload_next;
    logic [10:0] pc_reg, pc_next;
    logic [1:0]  sel_reg, sel_next;
    logic        casc_reg, casc_next;
    logic        irq_en_reg, irq_en_next;
    logic        en_reg, en_next;

    logic [11:0] pc_inc;
    logic [11:0] period;
    logic [11:0] pc_wrapped;
    logic        wrap;
    logic        step;
    logic        ovf;

    assign pc_inc     = {1'b0, pc_reg} + 12'd1;
    assign period     = cpt_pkg::prescale_period(sel_reg);
    assign wrap       = (pc_inc >= period);
    assign pc_wrapped = wrap ? (pc_inc - period) : pc_inc;

    // A prescaled timer steps when its prescaler wraps; a cascaded one on the lower overflow.
    assign step = cmd.tick && en_reg && (casc_reg ? carry_in : wrap);
    assign ovf  = step && (count_reg == 16'hFFFF);

    always_comb
    begin
        count_next  = count_reg;
        reload_next = reload_reg;
        pc_next     = pc_reg;
        sel_next    = sel_reg;
        casc_next   = casc_reg;
        irq_en_next = irq_en_reg;
        en_next     = en_reg;
        if (cmd.tick)
        begin
            if (en_reg && !casc_reg)
            begin
                pc_next = pc_wrapped[10:0];
            end
            if (step)
            begin
                count_next = ovf ? reload_reg : count_reg + 16'd1;
            end
        end
        if (cmd.wr_count)
        begin
            reload_next = cmd.data;
        end
        if (cmd.wr_ctrl)
        begin
            pc_next     = 11'd0;
            sel_next    = cmd.data[1:0];
            casc_next   = cmd.data[cpt_pkg::CTRL_CASC_BIT];
            irq_en_next = cmd.data[cpt_pkg::CTRL_IRQ_BIT];
            en_next     = cmd.data[cpt_pkg::CTRL_EN_BIT];
            if (!en_reg && cmd.data[cpt_pkg::CTRL_EN_BIT])
            begin
                count_next = reload_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 16'd0;
            reload_reg <= 16'd0;
            pc_reg     <= 11'd0;
            sel_reg    <= 2'd0;
            casc_reg   <= 1'b0;
            irq_en_reg <= 1'b0;
            en_reg     <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            reload_reg <= reload_next;
            pc_reg     <= pc_next;
            sel_reg    <= sel_next;
            casc_reg   <= casc_next;
            irq_en_reg <= irq_en_next;
            en_reg     <= en_next;
        end
    end

    assign stat.count = count_reg;
    assign stat.ctrl  = cpt_pkg::pack_ctrl(sel_reg, casc_reg, irq_en_reg, en_reg);
    assign stat.ovf   = ovf;

endmodule
`default_nettype wire

// ===== rtl/core/cascading_prescaled_up_timers.sv =====
// Top level: bank of cascadable prescaled up-timers behind halfword registers.
// An accepted beat waits in the input register and is processed as it moves into the result
// register. Throughput: one beat per cycle while result.ready holds; the limit is the single
// register-to-register pass through the timer bank, with the overflow ripple between timers.
// Reset: rst_n clears every counter, reload value, prescaler and control bit at once,
// and empties both the input and the result register.
`default_nettype none
module cascading_prescaled_up_timers #(
    parameter int NUM_TIMERS = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cpt_in_if.sink    item,
    cpt_out_if.source result
);

    localparam int IRQ_BITS = (NUM_TIMERS < cpt_pkg::IRQ_WIDTH) ? NUM_TIMERS
                                                                : cpt_pkg::IRQ_WIDTH;

    // Input register: holds the beat being worked on in this cycle.
    logic        s1_valid_reg;
    logic [1:0]  op_reg;
    logic [3:0]  offset_reg;
    logic [15:0] data_reg;

    // Result register: parts the timer bank from the downstream side.
    logic        out_valid_reg;
    logic [15:0] read_data_reg, read_data_next;
    logic [3:0]  irq_reg, irq_next;

    logic        advance;
    logic [1:0]  tidx;
    logic        addr_ok;

    cpt_pkg::timer_cmd_t  cmd  [NUM_TIMERS];
    cpt_pkg::timer_stat_t stat [NUM_TIMERS];

    // The held beat is processed, and the timer state updated, in the cycle that it moves
    // into the result register. That keeps every state change in beat order.
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;

    // Timer t's counter sits at byte offset 4*t and its control word at 4*t+2.
    assign tidx    = offset_reg[3:2];
    assign addr_ok = !offset_reg[0] && (int'(tidx) < NUM_TIMERS);

    genvar t;
    generate
        for (t = 0; t < NUM_TIMERS; t++)
        begin : g_timer
            logic sel_hit;
            logic carry_in;

            assign sel_hit = advance && (op_reg == cpt_pkg::OP_WRITE) && addr_ok &&
                             (int'(tidx) == t);

            assign cmd[t].tick     = advance && (op_reg == cpt_pkg::OP_TICK);
            assign cmd[t].wr_count = sel_hit && !offset_reg[1];
            assign cmd[t].wr_ctrl  = sel_hit && offset_reg[1];
            assign cmd[t].data     = data_reg;

            // The first timer has nothing below it to cascade from.
            if (t == 0)
            begin : g_first
                assign carry_in = 1'b0;
            end
            else
            begin : g_chain
                assign carry_in = stat[t-1].ovf;
            end

            cpt_timer u_timer (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd[t]),
                .carry_in (carry_in),
                .stat     (stat[t])
            );
        end
    endgenerate

    // Read data is a small select across the timers; anything other than a valid read is 0.
    always_comb
    begin
        read_data_next = 16'h0000;
        if ((op_reg == cpt_pkg::OP_READ) && addr_ok)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (int'(tidx) == i)
                begin
                    read_data_next = offset_reg[1] ? stat[i].ctrl : stat[i].count;
                end
            end
        end
    end

    // Only the lowest timers own an interrupt bit. Overflow only happens on a tick.
    always_comb
    begin
        irq_next = 4'h0;
        for (int i = 0; i < IRQ_BITS; i++)
        begin
            irq_next[i] = stat[i].ovf && stat[i].ctrl[cpt_pkg::CTRL_IRQ_BIT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            op_reg     <= item.op;
            offset_reg <= item.offset;
            data_reg   <= item.write_data;
        end
        if (advance)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.read_data  = read_data_reg;
    assign result.irq_pulses = irq_reg;

    // A beat that is not a tick must never deliver interrupt pulses.
    a_irq_only_on_tick : assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg != cpt_pkg::OP_TICK) |=> (irq_reg == 4'h0))
        else $error("interrupt pulse on a beat that is not a tick");

    // Read data is zero for every beat that is not a read.
    a_rdata_zero : assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg != cpt_pkg::OP_READ) |=> (read_data_reg == 16'h0000))
        else $error("non-zero read data on a beat that is not a read");

    // A held beat that cannot move on must stay in the input register unchanged.
    a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(op_reg) &&
                                     $stable(offset_reg) && $stable(data_reg))
        else $error("held input beat lost or changed while stalled");

endmodule
`default_nettype wire
